// File: rtl/core/lpmm_pkg.sv
// lpmm_pkg: shared types and constants for the linear probing min map
// no dependencies
`default_nettype none

package lpmm_pkg;

    // number of slots, must be a power of two
    localparam int TABLE_DEPTH = 4096;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int KEY_W       = 64;
    localparam int VAL_W       = 7;

    localparam logic       OP_MIN     = 1'b0;
    localparam logic       OP_FIND    = 1'b1;

    localparam logic [1:0] ST_PRESENT = 2'd0;
    localparam logic [1:0] ST_ABSENT  = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;

    typedef logic [IDX_W-1:0] t_idx;

    typedef struct packed {
        logic             op;
        logic [KEY_W-1:0] lookup_key;
        logic [VAL_W-1:0] new_value;
    } t_req;

    typedef struct packed {
        logic [1:0]       status;
        logic [VAL_W-1:0] stored_value;
    } t_rsp;

    typedef struct packed {
        logic             valid;
        logic [VAL_W-1:0] value;
        logic [KEY_W-1:0] key;
    } t_slot;

    typedef struct packed {
        logic  we;
        t_idx  waddr;
        t_slot wdata;
        t_idx  raddr;
    } t_ram_req;

endpackage

`default_nettype wire

// File: rtl/core/lpmm_ram.sv
// lpmm_ram: generic simple dual port ram, one write port, one registered read port
// no dependencies
`default_nettype none

module lpmm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// File: rtl/core/lpmm_ctrl.sv
// lpmm_ctrl: probe sequencer, clear pass, key compare and result register
// depends on lpmm_pkg
`default_nettype none

module lpmm_ctrl
    import lpmm_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     start,
    output logic          busy,
    input  wire t_req     i_req,
    output logic          o_done,
    output t_rsp          o_rsp,
    output t_ram_req      o_ram,
    input  wire t_slot    i_rdata
);

    typedef enum logic [2:0] {
        S_CLEAR = 3'b001,
        S_IDLE  = 3'b010,
        S_CHECK = 3'b100
    } t_state;

    t_state r_state, n_state;
    t_idx   r_pos, n_pos;
    t_idx   r_cnt, n_cnt;
    t_req   r_req, n_req;
    logic   r_done, n_done;
    t_rsp   r_rsp, n_rsp;
    t_idx   nxt_pos;

    assign nxt_pos = r_pos + t_idx'(1);

    always_comb begin
        n_state     = r_state;
        n_pos       = r_pos;
        n_cnt       = r_cnt;
        n_req       = r_req;
        n_done      = 1'b0;
        n_rsp       = r_rsp;
        o_ram.we    = 1'b0;
        o_ram.waddr = r_pos;
        o_ram.wdata = '{valid: 1'b1, value: r_req.new_value, key: r_req.lookup_key};
        o_ram.raddr = r_pos;
        case (r_state)
            S_CLEAR: begin
                o_ram.we          = 1'b1;
                o_ram.wdata.valid = 1'b0;
                n_pos             = nxt_pos;
                if (r_pos == '1) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_ram.raddr = i_req.lookup_key[IDX_W-1:0];
                if (start) begin
                    n_req   = i_req;
                    n_pos   = i_req.lookup_key[IDX_W-1:0];
                    n_cnt   = '0;
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                o_ram.raddr = nxt_pos;
                if (!i_rdata.valid) begin
                    n_done       = 1'b1;
                    n_state      = S_IDLE;
                    n_rsp.status = ST_ABSENT;
                    if (r_req.op == OP_MIN) begin
                        o_ram.we           = 1'b1;
                        n_rsp.stored_value = r_req.new_value;
                    end else begin
                        n_rsp.stored_value = '0;
                    end
                end else if (i_rdata.key == r_req.lookup_key) begin
                    n_done             = 1'b1;
                    n_state            = S_IDLE;
                    n_rsp.status       = ST_PRESENT;
                    n_rsp.stored_value = i_rdata.value;
                    if (r_req.op == OP_MIN && r_req.new_value < i_rdata.value) begin
                        o_ram.we           = 1'b1;
                        n_rsp.stored_value = r_req.new_value;
                    end
                end else if (r_cnt == '1) begin
                    n_done             = 1'b1;
                    n_state            = S_IDLE;
                    n_rsp.status       = ST_FULL;
                    n_rsp.stored_value = '0;
                end else begin
                    n_pos = nxt_pos;
                    n_cnt = r_cnt + t_idx'(1);
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_pos   <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pos   <= n_pos;
            r_done  <= n_done;
        end
        r_cnt <= n_cnt;
        r_req <= n_req;
        r_rsp <= n_rsp;
    end

    assign busy   = (r_state != S_IDLE);
    assign o_done = r_done;
    assign o_rsp  = r_rsp;

    a_done_after_check: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(r_state == S_CHECK))
        else $error("result without a probe");

    a_write_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ram.we |-> (r_state == S_CLEAR || r_state == S_CHECK))
        else $error("ram write outside clear or probe");

    a_accept_probe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (r_state == S_CHECK && !o_done))
        else $error("accepted request did not start probing");

    a_full_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_rsp.status == ST_FULL) |-> (o_rsp.stored_value == '0))
        else $error("full result carries a value");

    a_full_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CHECK && i_rdata.valid && r_cnt == '1
         && i_rdata.key != r_req.lookup_key) |-> !o_ram.we)
        else $error("write on full table");

endmodule

`default_nettype wire

// File: rtl/core/linear_probe_min_map.sv
// linear_probe_min_map: hash table of 64-bit keys with 7-bit minimized values
// depends on lpmm_pkg, lpmm_ram, lpmm_ctrl
//
//   channel   handshake          payload
//   request   start / busy       i_req  (op, lookup_key, new_value)
//   result    o_done strobe      o_rsp  (status, stored_value)
//
// a request makes one slot ram read per probe,
// with the result strobe in the cycle after the last probe
// a full table costs TABLE_DEPTH probes
// after reset a clear pass zeroes the valid marks of all TABLE_DEPTH slots, busy high
// the o_done strobe is shown for one cycle only, o_rsp holds its value until the next result
`default_nettype none

module linear_probe_min_map
    import lpmm_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  start,
    output logic       busy,
    input  wire t_req  i_req,
    output logic       o_done,
    output t_rsp       o_rsp
);

    t_ram_req ram_req;
    t_slot    ram_rdata;

    lpmm_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_req   (i_req),
        .o_done  (o_done),
        .o_rsp   (o_rsp),
        .o_ram   (ram_req),
        .i_rdata (ram_rdata)
    );

    lpmm_ram #(
        .WIDTH ($bits(t_slot)),
        .DEPTH (TABLE_DEPTH)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (ram_req.we),
        .i_waddr (ram_req.waddr),
        .i_wdata (ram_req.wdata),
        .i_raddr (ram_req.raddr),
        .o_rdata (ram_rdata)
    );

endmodule

`default_nettype wire
